>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the depth tested pixel writer.
// Checks are compiled for simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rst, prop, msg)
`define CHK_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/dtpw_pkg.sv
// Types and codes of the depth tested pixel writer.
// No dependencies; imported by every module of the block.
package dtpw_pkg;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEPTH_TEST   = 2'd2;

   localparam logic [1:0] REQ_DRAW  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   localparam logic [2:0] OUT_DRAWN    = 3'd0;
   localparam logic [2:0] OUT_REJECTED = 3'd1;
   localparam logic [2:0] OUT_BOUNDS   = 3'd2;
   localparam logic [2:0] OUT_CLEARED  = 3'd3;
   localparam logic [2:0] OUT_READ     = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic signed [23:0] depth_in;
      logic [7:0]         red_in;
      logic [7:0]         green_in;
      logic [7:0]         blue_in;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         outcome;
      logic [7:0]         red_out;
      logic [7:0]         green_out;
      logic [7:0]         blue_out;
      logic signed [23:0] depth_out;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] frame_width;
      logic [CSR_DATA_BITS-1:0] frame_height;
      logic                     depth_test_enable;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic colour_we;
      logic depth_we;
      logic clear_start;
   } store_ctl_type;

   function automatic int addr_bits_of(int entries);
      return (entries > 1) ? $clog2(entries) : 1;
   endfunction

endpackage

>>> hw/rtl/depth_tested_pixel_writer_unit.sv
// Depth tested pixel writer: an accepted word passes the a and b stages and the result register;
// throughput one word per cycle while nothing stalls the pipe, with a one-entry write forward across the
// read-before-write memory ports. A clear sweeps all MAX_WIDTH*MAX_HEIGHT entries (65536 by
// default), one entry per cycle, stalling requests; configuration writes are taken as ever.
// Synchronous reset restores the registers and starts the same sweep.
`include "assert_macros.svh"
module depth_tested_pixel_writer_unit import dtpw_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int DEPTH_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_word,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int ENTRIES   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = addr_bits_of(ENTRIES);
   localparam int EXT       = (DEPTH_BITS > 24) ? DEPTH_BITS : 24;

   cfg_type cfg_ff;

   logic                         advance;
   logic                         take;
   logic                         clear_ahead;
   logic                         store_busy;
   store_ctl_type                ctl;

   logic                         loc_inb;
   logic [ADDR_BITS-1:0]         loc_addr;
   logic signed [DEPTH_BITS-1:0] loc_depth;

   logic                         a_valid_ff, a_valid_in;
   logic [1:0]                   a_code_ff;
   logic                         a_inb_ff;
   logic [ADDR_BITS-1:0]         a_addr_ff;
   logic signed [DEPTH_BITS-1:0] a_depth_ff;
   logic [23:0]                  a_rgb_ff;

   logic                         b_valid_ff;
   logic [1:0]                   b_code_ff;
   logic                         b_inb_ff;
   logic [ADDR_BITS-1:0]         b_addr_ff;
   logic signed [DEPTH_BITS-1:0] b_depth_ff;
   logic [23:0]                  b_rgb_ff;

   logic [23:0]                  rd_colour;
   logic signed [DEPTH_BITS-1:0] rd_depth;
   logic [23:0]                  cur_colour;
   logic signed [DEPTH_BITS-1:0] cur_depth;
   logic signed [EXT-1:0]        cur_depth_ext;
   logic                         colour_hit;
   logic                         depth_hit;
   logic                         clear_hit;

   logic                         fw_col_valid_ff;
   logic                         fw_dep_valid_ff;
   logic [ADDR_BITS-1:0]         fw_addr_ff;
   logic [23:0]                  fw_colour_ff;
   logic signed [DEPTH_BITS-1:0] fw_depth_ff;

   logic                         rsp_valid_ff;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= CSR_DATA_BITS'(256);
         cfg_ff.frame_height      <= CSR_DATA_BITS'(256);
         cfg_ff.depth_test_enable <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width       <= csr_wdata;
            CSR_FRAME_HEIGHT: cfg_ff.frame_height      <= csr_wdata;
            CSR_DEPTH_TEST:   cfg_ff.depth_test_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   dtpw_locate #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .DEPTH_BITS(DEPTH_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_locate (
      .req      (req_word),
      .cfg      (cfg_ff),
      .in_bounds(loc_inb),
      .addr     (loc_addr),
      .depth_sat(loc_depth)
   );

   dtpw_store #(
      .DEPTH_BITS(DEPTH_BITS),
      .ADDR_BITS (ADDR_BITS),
      .ENTRIES   (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (a_addr_ff),
      .wr_addr  (b_addr_ff),
      .wr_colour(b_rgb_ff),
      .wr_depth (b_depth_ff),
      .rd_colour(rd_colour),
      .rd_depth (rd_depth),
      .busy     (store_busy)
   );

   // the whole pipe moves when the result register is free or being taken
   always_comb begin
      advance     = !rsp_valid_ff || !rsp_stall;
      clear_ahead = (a_valid_ff && (a_code_ff == REQ_CLEAR)) ||
                    (b_valid_ff && (b_code_ff == REQ_CLEAR));
      req_stall   = !advance || store_busy || clear_ahead;
      take        = req_valid && !req_stall;
      // drop the unused request code at the door
      a_valid_in  = advance ? (take && (req_word.req_type != REQ_NONE)) : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (advance) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_code_ff  <= req_word.req_type;
         a_inb_ff   <= loc_inb;
         a_addr_ff  <= loc_addr;
         a_depth_ff <= loc_depth;
         a_rgb_ff   <= {req_word.red_in, req_word.green_in, req_word.blue_in};
         b_code_ff  <= a_code_ff;
         b_inb_ff   <= a_inb_ff;
         b_addr_ff  <= a_addr_ff;
         b_depth_ff <= a_depth_ff;
         b_rgb_ff   <= a_rgb_ff;
      end
   end

   // depth test and result build; forward the write made as this word was read
   always_comb begin
      cur_colour = (fw_col_valid_ff && (fw_addr_ff == b_addr_ff)) ? fw_colour_ff : rd_colour;
      cur_depth  = (fw_dep_valid_ff && (fw_addr_ff == b_addr_ff)) ? fw_depth_ff : rd_depth;
      cur_depth_ext = EXT'(cur_depth);
      rsp_word_in = '0;
      colour_hit  = 1'b0;
      depth_hit   = 1'b0;
      clear_hit   = 1'b0;
      unique case (b_code_ff)
         REQ_CLEAR: begin
            rsp_word_in.outcome = OUT_CLEARED;
            clear_hit = 1'b1;
         end
         REQ_READ: begin
            if (b_inb_ff) begin
               rsp_word_in.outcome   = OUT_READ;
               rsp_word_in.red_out   = cur_colour[23:16];
               rsp_word_in.green_out = cur_colour[15:8];
               rsp_word_in.blue_out  = cur_colour[7:0];
               rsp_word_in.depth_out = cur_depth_ext[23:0];
            end else begin
               rsp_word_in.outcome = OUT_BOUNDS;
            end
         end
         REQ_DRAW: begin
            if (!b_inb_ff) begin
               rsp_word_in.outcome = OUT_BOUNDS;
            end else if (!cfg_ff.depth_test_enable) begin
               rsp_word_in.outcome = OUT_DRAWN;
               colour_hit = 1'b1;
            end else if (b_depth_ff > cur_depth) begin
               rsp_word_in.outcome = OUT_DRAWN;
               colour_hit = 1'b1;
               depth_hit  = 1'b1;
            end else begin
               rsp_word_in.outcome = OUT_REJECTED;
            end
         end
         default: begin
            rsp_word_in = '0;
         end
      endcase
      ctl.rd_en       = advance;
      ctl.colour_we   = advance && b_valid_ff && colour_hit;
      ctl.depth_we    = advance && b_valid_ff && depth_hit;
      ctl.clear_start = advance && b_valid_ff && clear_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_col_valid_ff <= 1'b0;
         fw_dep_valid_ff <= 1'b0;
      end else if (advance) begin
         fw_col_valid_ff <= ctl.colour_we;
         fw_dep_valid_ff <= ctl.depth_we;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fw_addr_ff   <= b_addr_ff;
         fw_colour_ff <= b_rgb_ff;
         fw_depth_ff  <= b_depth_ff;
      end
   end

   // result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `CHK_ASSERT(a_sweep_blocks_req, clock, reset, store_busy |-> req_stall, "request taken during sweep")
   `CHK_ASSERT(a_sweep_no_write, clock, reset, store_busy |-> !(ctl.colour_we || ctl.depth_we), "pipeline write during sweep")
   `CHK_ASSERT(a_clear_pipe_empty, clock, reset, ctl.clear_start |-> !a_valid_ff, "clear started behind a live word")
   `CHK_ASSERT_NR(a_reset_sweeps, clock, reset |=> store_busy, "no sweep after reset")

endmodule

>>> hw/rtl/dtpw_locate.sv
// Request decode: bounds check, entry address and depth saturation.
// Depends on dtpw_pkg.
module dtpw_locate import dtpw_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int DEPTH_BITS = 24,
   parameter int ADDR_BITS  = 16
) (
   input  req_word_type                 req,
   input  cfg_type                      cfg,
   output logic                         in_bounds,
   output logic [ADDR_BITS-1:0]         addr,
   output logic signed [DEPTH_BITS-1:0] depth_sat
);

   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int PB  = 15 + WB;
   localparam int EXT = (DEPTH_BITS > 24) ? DEPTH_BITS : 24;
   localparam logic signed [EXT-1:0] DMAX = EXT'((64'sd1 <<< (DEPTH_BITS - 1)) - 64'sd1);
   localparam logic signed [EXT-1:0] DMIN = EXT'(-(64'sd1 <<< (DEPTH_BITS - 1)));

   logic [15:0]           w16;
   logic [15:0]           h16;
   logic [WB-1:0]         eff_w;
   logic [HB-1:0]         eff_h;
   logic                  in_x;
   logic                  in_y;
   logic [PB-1:0]         prod;
   logic [PB-1:0]         sum;
   logic signed [EXT-1:0] z_ext;
   logic signed [EXT-1:0] z_sat;

   always_comb begin
      w16   = 16'(cfg.frame_width);
      h16   = 16'(cfg.frame_height);
      // saturate oversized dimensions to the store geometry
      eff_w = (w16 > 16'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(w16);
      eff_h = (h16 > 16'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(h16);
      in_x  = !req.x_coord[15] && ({1'b0, req.x_coord[14:0]} < 16'(eff_w));
      in_y  = !req.y_coord[15] && ({1'b0, req.y_coord[14:0]} < 16'(eff_h));
      in_bounds = in_x && in_y;
      prod  = PB'(req.y_coord[14:0]) * PB'(eff_w);
      sum   = prod + PB'(req.x_coord[14:0]);
      addr  = sum[ADDR_BITS-1:0];
      z_ext = EXT'(req.depth_in);
      if (z_ext > DMAX) begin
         z_sat = DMAX;
      end else if (z_ext < DMIN) begin
         z_sat = DMIN;
      end else begin
         z_sat = z_ext;
      end
      depth_sat = z_sat[DEPTH_BITS-1:0];
   end

endmodule

>>> hw/rtl/dtpw_store.sv
// Colour and depth memories with registered reads and a clearing sweep.
// Depends on dtpw_pkg.
module dtpw_store import dtpw_pkg::*; #(
   parameter int DEPTH_BITS = 24,
   parameter int ADDR_BITS  = 16,
   parameter int ENTRIES    = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  store_ctl_type                ctl,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   input  logic [ADDR_BITS-1:0]         wr_addr,
   input  logic [23:0]                  wr_colour,
   input  logic signed [DEPTH_BITS-1:0] wr_depth,
   output logic [23:0]                  rd_colour,
   output logic signed [DEPTH_BITS-1:0] rd_depth,
   output logic                         busy
);

   localparam logic [ADDR_BITS-1:0]  LAST = ADDR_BITS'(ENTRIES - 1);
   localparam logic [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS - 1){1'b0}}};

   logic [23:0]           colour_mem [ENTRIES];
   logic [DEPTH_BITS-1:0] depth_mem  [ENTRIES];

   logic                  busy_ff, busy_in;
   logic [ADDR_BITS-1:0]  sweep_ff, sweep_in;
   logic [23:0]           rd_colour_ff;
   logic [DEPTH_BITS-1:0] rd_depth_ff;

   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      if (ctl.clear_start) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end else if (busy_ff) begin
         if (sweep_ff == LAST) begin
            busy_in = 1'b0;
         end else begin
            sweep_in = sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         colour_mem[sweep_ff] <= '0;
      end else if (ctl.colour_we) begin
         colour_mem[wr_addr] <= wr_colour;
      end
      if (ctl.rd_en) begin
         rd_colour_ff <= colour_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         depth_mem[sweep_ff] <= DMIN;
      end else if (ctl.depth_we) begin
         depth_mem[wr_addr] <= wr_depth;
      end
      if (ctl.rd_en) begin
         rd_depth_ff <= depth_mem[rd_addr];
      end
   end

   assign rd_colour = rd_colour_ff;
   assign rd_depth  = rd_depth_ff;
   assign busy      = busy_ff;

endmodule

>>> bench/depth_tested_pixel_writer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_tested_pixel_writer_unit: random draw, read and clear words
// against a mirror of the colour and depth stores. Depends on dtpw_pkg and the unit's RTL.
module depth_tested_pixel_writer_unit_tb;
   import dtpw_pkg::*;

   localparam int MAX_DIM    = 256;
   localparam int PIXELS     = MAX_DIM * MAX_DIM;
   localparam int PHASE_ITEMS = 230;
   localparam int IDLE_LIMIT = 300000;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic signed [23:0] DEPTH_FLOOR = 24'sh800000;
   localparam logic signed [23:0] DEPTH_CEIL  = 24'sh7FFFFF;

   typedef struct packed {
      logic [8:0] cols;
      logic [8:0] rows;
      logic [8:0] test_word;
   } frame_setting_type;

   // Mirror of the frame and the queue of results still owed by the unit.
   class frame_mirror_type;
      logic [23:0]        colour_at [PIXELS];
      logic signed [23:0] depth_at [PIXELS];
      int                 frame_width;
      int                 frame_height;
      bit                 depth_test;
      rsp_word_type       results_due [$];
      int                 results_seen;
      int                 mismatches;

      function new();
         frame_width  = MAX_DIM;
         frame_height = MAX_DIM;
         depth_test   = 1'b1;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < PIXELS; i++) begin
            colour_at[i] = '0;
            depth_at[i]  = DEPTH_FLOOR;
         end
      endfunction

      function int span_x();
         return (frame_width > MAX_DIM) ? MAX_DIM : frame_width;
      endfunction

      function int span_y();
         return (frame_height > MAX_DIM) ? MAX_DIM : frame_height;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void set_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_FRAME_WIDTH:  frame_width = value;
            CSR_FRAME_HEIGHT: frame_height = value;
            CSR_DEPTH_TEST:   depth_test = value[0];
            default: ;
         endcase
      endfunction

      function void take_request(req_word_type w);
         rsp_word_type r;
         int x, y, cols, rows, slot;
         if (w.req_type == REQ_NONE)
            return;
         r    = '0;
         x    = $signed(w.x_coord);
         y    = $signed(w.y_coord);
         cols = span_x();
         rows = span_y();
         if (w.req_type == REQ_CLEAR) begin
            wipe();
            r.outcome = OUT_CLEARED;
         end else if (x < 0 || y < 0 || x >= cols || y >= rows) begin
            r.outcome = OUT_BOUNDS;
         end else begin
            slot = y * cols + x;
            if (w.req_type == REQ_READ) begin
               r.outcome = OUT_READ;
               {r.red_out, r.green_out, r.blue_out} = colour_at[slot];
               r.depth_out = depth_at[slot];
            end else if (!depth_test || $signed(w.depth_in) > $signed(depth_at[slot])) begin
               colour_at[slot] = {w.red_in, w.green_in, w.blue_in};
               // with the test off the stored depth stays put
               if (depth_test)
                  depth_at[slot] = w.depth_in;
               r.outcome = OUT_DRAWN;
            end else begin
               r.outcome = OUT_REJECTED;
            end
         end
         results_due.push_back(r);
      endfunction

      task flag_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task match_result(rsp_word_type got);
         rsp_word_type want;
         results_seen++;
         if (results_due.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
            return;
         end
         want = results_due.pop_front();
         if (got.outcome !== want.outcome)
            flag_mismatch($sformatf("result %0d outcome %0d, expected %0d",
                                    results_seen, got.outcome, want.outcome));
         if (got.red_out !== want.red_out)
            flag_mismatch($sformatf("result %0d red %0h, expected %0h",
                                    results_seen, got.red_out, want.red_out));
         if (got.green_out !== want.green_out)
            flag_mismatch($sformatf("result %0d green %0h, expected %0h",
                                    results_seen, got.green_out, want.green_out));
         if (got.blue_out !== want.blue_out)
            flag_mismatch($sformatf("result %0d blue %0h, expected %0h",
                                    results_seen, got.blue_out, want.blue_out));
         if (got.depth_out !== want.depth_out)
            flag_mismatch($sformatf("result %0d depth %0h, expected %0h",
                                    results_seen, got.depth_out, want.depth_out));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_word_type             req_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_word_type             rsp_word;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   frame_mirror_type mirror;
   bit               quiet = 1'b0;
   int               idle_cycles = 0;

   depth_tested_pixel_writer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_word_type make_word(logic [1:0] kind, logic [15:0] x,
                                              logic [15:0] y, logic [23:0] z,
                                              logic [23:0] rgb);
      req_word_type w;
      w.req_type = kind;
      w.x_coord  = x;
      w.y_coord  = y;
      w.depth_in = z;
      {w.red_in, w.green_in, w.blue_in} = rgb;
      return w;
   endfunction

   // Favour a few pixels near the origin so that draws meet earlier draws.
   function automatic logic [15:0] pick_coord(int span);
      int roll, hot;
      roll = $urandom_range(0, 99);
      hot  = (span < 6) ? span : 6;
      if (roll < 55 && hot > 0)
         return 16'($urandom_range(0, hot - 1));
      if (roll < 75 && span > 0)
         return 16'($urandom_range(0, span - 1));
      if (roll < 90) begin
         case ($urandom_range(0, 2))
            0:       return 16'(span);
            1:       return 16'(-1);
            default: return 16'(span - 1);
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic logic [23:0] pick_depth();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 24'(int'($urandom_range(0, 16)) - 8);
      if (roll < 60) begin
         case ($urandom_range(0, 3))
            0:       return DEPTH_FLOOR;
            1:       return DEPTH_FLOOR + 24'sd1;
            2:       return DEPTH_CEIL;
            default: return DEPTH_CEIL - 24'sd1;
         endcase
      end
      return 24'($urandom);
   endfunction

   // Hold the word until taken, then note it in the mirror.
   task automatic send_word(req_word_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.take_request(w);
   endtask

   // Drop valid and wait for every outstanding result, plus some slack.
   task automatic settle(int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      mirror.set_register(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : result_side
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         mirror.match_result(rsp_word);
      end
   end

   initial begin : stimulus
      frame_setting_type plan [8];
      logic [1:0]        kind;
      int                done, roll, since_clear;
      mirror = new();
      plan = '{'{9'd256, 9'd256, 9'h001}, '{9'd1,   9'd1,   9'h001},
               '{9'd7,   9'd5,   9'h000}, '{9'd0,   9'd9,   9'h001},
               '{9'd300, 9'd511, 9'h001}, '{9'd13,  9'd0,   9'h000},
               '{9'd256, 9'd3,   9'h1FE}, '{9'd511, 9'd2,   9'h1FF}};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words against the reset geometry, depth test on
      send_word(make_word(REQ_READ, 16'd0, 16'd0, 24'd0, 24'd0));
      send_word(make_word(REQ_DRAW, 16'd0, 16'd0, DEPTH_FLOOR, 24'hFFFFFF));
      send_word(make_word(REQ_DRAW, 16'd0, 16'd0, DEPTH_FLOOR + 24'sd1, 24'h123456));
      send_word(make_word(REQ_DRAW, 16'd0, 16'd0, DEPTH_FLOOR + 24'sd1, 24'hABCDEF));
      send_word(make_word(REQ_DRAW, 16'd255, 16'd255, DEPTH_CEIL, 24'hFFFFFF));
      send_word(make_word(REQ_DRAW, 16'd255, 16'd255, DEPTH_CEIL, 24'h000000));
      send_word(make_word(REQ_READ, 16'd255, 16'd255, 24'd0, 24'd0));
      send_word(make_word(REQ_DRAW, 16'd256, 16'd0, DEPTH_CEIL, 24'h0F0F0F));
      send_word(make_word(REQ_DRAW, 16'd0, 16'd256, DEPTH_CEIL, 24'hF0F0F0));
      send_word(make_word(REQ_DRAW, 16'hFFFF, 16'd5, DEPTH_CEIL, 24'h555555));
      send_word(make_word(REQ_DRAW, 16'h8000, 16'h7FFF, DEPTH_CEIL, 24'hAAAAAA));
      send_word(make_word(REQ_READ, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF));
      send_word(make_word(REQ_NONE, 16'd0, 16'd0, DEPTH_CEIL, 24'($urandom)));
      send_word(make_word(REQ_READ, 16'd0, 16'd0, 24'd0, 24'd0));
      send_word(make_word(REQ_CLEAR, 16'd3, 16'd3, 24'd0, 24'd0));
      send_word(make_word(REQ_READ, 16'd0, 16'd0, 24'd0, 24'd0));
      send_word(make_word(REQ_READ, 16'd255, 16'd255, 24'd0, 24'd0));
      send_word(make_word(REQ_DRAW, 16'd1, 16'd0, 24'hFFFFFF, 24'h00FF00));
      send_word(make_word(REQ_READ, 16'd1, 16'd0, 24'd0, 24'd0));

      since_clear = 0;
      foreach (plan[p]) begin
         settle(4);
         write_register(CSR_FRAME_WIDTH, plan[p].cols);
         write_register(CSR_FRAME_HEIGHT, plan[p].rows);
         write_register(CSR_DEPTH_TEST, plan[p].test_word);
         if (p == 3)
            write_register(CSR_SPARE, 9'($urandom));
         done = 0;
         while (done < PHASE_ITEMS) begin
            if (done % 50 == 0)
               quiet = ($urandom_range(0, 3) == 0);
            if ((p == 0 && done == 100) || $urandom_range(0, 149) == 0)
               settle(0);
            roll = $urandom_range(0, 99);
            // clears sweep the whole store, so keep them rare
            if (roll < 4)
               kind = REQ_NONE;
            else if (roll < 6 && since_clear > 350)
               kind = REQ_CLEAR;
            else if (roll < 32)
               kind = REQ_READ;
            else
               kind = REQ_DRAW;
            send_word(make_word(kind, pick_coord(mirror.span_x()),
                                pick_coord(mirror.span_y()), pick_depth(),
                                24'($urandom)));
            if (kind != REQ_NONE) begin
               done++;
               since_clear = (kind == REQ_CLEAR) ? 0 : since_clear + 1;
            end
         end
      end

      quiet = 1'b0;
      settle(8);
      if (mirror.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/dtpw_pkg.sv
hw/rtl/dtpw_locate.sv
hw/rtl/dtpw_store.sv
hw/rtl/depth_tested_pixel_writer_unit.sv
bench/depth_tested_pixel_writer_unit_tb.sv
